>>> hw/rtl/rlm_pkg.sv
// Shared types and constants for the RMS level meter.
package rlm_pkg;

  // Decay factor register width and its Q0.16 fraction width.
  localparam int unsigned CfgW      = 16;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned LevelW    = 16;

  // Reset value of the decay factor, about 0.92 in Q0.16.
  localparam logic [CfgW-1:0] DecayReset = 16'd60293;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc;        // accept one sample word into the accumulator
    logic div_load;   // move sum and count into the divider, clear accumulator
    logic div_step;   // one restoring divider step
    logic sqrt_load;  // move the quotient into the root unit
    logic sqrt_step;  // one root step
    logic update;     // update the held level
  } cmd_t;

endpackage

>>> hw/rtl/rlm_ctrl.sv
// Controller state machine of the RMS level meter.
module rlm_ctrl #(
  parameter int unsigned DIV_STEPS  = 45,
  parameter int unsigned SQRT_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_of_buffer,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output rlm_pkg::cmd_t cmd
);

  localparam int unsigned CtrW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [4:0] {
    S_ACCUM   = 5'b00001,
    S_DLOAD   = 5'b00010,
    S_DIV     = 5'b00100,
    S_SQLOAD  = 5'b01000,
    S_SQRT    = 5'b10000
  } state_t;

  // The level update waits in its own state so the output slot can free up.
  typedef enum logic [1:0] {
    U_IDLE = 2'b01,
    U_WAIT = 2'b10
  } upd_t;

  state_t          state_r, state_nxt;
  upd_t            upd_r, upd_nxt;
  logic [CtrW-1:0] step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            slot_free;
  logic            div_done;
  logic            sqrt_done;

  assign in_stall  = (state_r != S_ACCUM) || (upd_r != U_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign div_done  = (step_r == CtrW'(DIV_STEPS - 1));
  assign sqrt_done = (step_r == CtrW'(SQRT_STEPS - 1));
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    upd_nxt       = upd_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_ACCUM: begin
        if (upd_r == U_WAIT) begin
          if (slot_free) begin
            cmd.update    = 1'b1;
            out_valid_nxt = 1'b1;
            upd_nxt       = U_IDLE;
          end
        end else if (accept) begin
          cmd.acc = 1'b1;
          if (in_last_of_buffer) begin
            state_nxt = S_DLOAD;
          end
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (div_done) begin
          state_nxt = S_SQLOAD;
        end
      end
      S_SQLOAD: begin
        cmd.sqrt_load = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (sqrt_done) begin
          state_nxt = S_ACCUM;
          upd_nxt   = U_WAIT;
        end
      end
      default: begin
        state_nxt = S_ACCUM;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACCUM;
      upd_r       <= U_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      upd_r       <= upd_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // A final word always starts the divider load next.
  a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_of_buffer) |=> (state_r == S_DLOAD))
    else $error("last word did not start the level computation");

  // A new result only appears right after a level update.
  a_out_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.update))
    else $error("result word raised without a level update");

  // The divider hands over to the root unit after its last step.
  a_div_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done) |=> (state_r == S_SQLOAD))
    else $error("divider did not hand over to the root unit");

  // An update never overwrites a result that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> slot_free)
    else $error("level update while the result word is held");
`endif

endmodule

>>> hw/rtl/rlm_dpath.sv
// Datapath of the RMS level meter: accumulator, divider, root unit, held level.
module rlm_dpath #(
  parameter int unsigned MAX_SAMPLES = 8192,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rlm_pkg::cmd_t                cmd,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  input  logic                         cfg_we,
  input  logic [rlm_pkg::CfgW-1:0]     cfg_data,
  output logic [rlm_pkg::LevelW-1:0]   out_level
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SqW   = 2 * SB;
  localparam int unsigned QW    = 2 * SB - 1;
  localparam int unsigned SumW  = 2 * SB - 1 + CntW;
  localparam int unsigned ProdW = SB + rlm_pkg::CfgW;

  logic [SumW-1:0]           sum_r, sum_nxt;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic [SumW-1:0]           dq_r, dq_nxt;
  logic [CntW-1:0]           rem_r, rem_nxt;
  logic [CntW-1:0]           dvs_r, dvs_nxt;
  logic [SqW-1:0]            rad_r, rad_nxt;
  logic [SB+1:0]             srem_r, srem_nxt;
  logic [SB-1:0]             root_r, root_nxt;
  logic [SB-1:0]             held_r, held_nxt;
  logic [rlm_pkg::CfgW-1:0]  decay_r, decay_nxt;

  logic [SB-1:0]             mag;
  logic [SqW-1:0]            square;
  logic                      room;
  logic [CntW:0]             rem_sh;
  logic [CntW:0]             rem_sub;
  logic                      qbit;
  logic [SB+1:0]             srem_sh;
  logic [SB+1:0]             trial;
  logic                      rbit;
  logic [ProdW-1:0]          prod;

  // Magnitude and square of the incoming word; the most negative code maps to 2^(SB-1).
  assign mag    = in_sample[SB-1] ? (~in_sample + 1'b1) : in_sample;
  assign square = SqW'(mag) * SqW'(mag);
  assign room   = (cnt_r < CntW'(MAX_SAMPLES));

  // Restoring divider step: one quotient bit per cycle.
  assign rem_sh  = {rem_r, dq_r[SumW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign qbit    = (rem_sh >= {1'b0, dvs_r});

  // Square root step: two radicand bits in, one root bit out per cycle.
  assign srem_sh = {srem_r[SB-1:0], rad_r[SqW-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign rbit    = (srem_sh >= trial);

  // Decay product of the held level.
  assign prod = ProdW'(held_r) * ProdW'(decay_r);

  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    rad_nxt   = rad_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    held_nxt  = held_r;
    decay_nxt = cfg_we ? cfg_data : decay_r;

    // Accumulate squares until the buffer limit is reached.
    if (cmd.acc && room) begin
      sum_nxt = sum_r + SumW'(square);
      cnt_nxt = cnt_r + 1'b1;
    end

    // Start the divide and clear the accumulator for the next buffer.
    if (cmd.div_load) begin
      dq_nxt  = sum_r;
      dvs_nxt = cnt_r;
      rem_nxt = '0;
      sum_nxt = '0;
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      dq_nxt  = {dq_r[SumW-2:0], qbit};
      rem_nxt = qbit ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
    end

    // The mean square always fits in QW bits.
    if (cmd.sqrt_load) begin
      rad_nxt  = SqW'(dq_r[QW-1:0]);
      srem_nxt = '0;
      root_nxt = '0;
    end

    if (cmd.sqrt_step) begin
      rad_nxt  = {rad_r[SqW-3:0], 2'b00};
      srem_nxt = rbit ? (srem_sh - trial) : srem_sh;
      root_nxt = {root_r[SB-2:0], rbit};
    end

    // Peak hold: take a larger level, otherwise decay the held one.
    if (cmd.update) begin
      if (root_r > held_r) begin
        held_nxt = root_r;
      end else begin
        held_nxt = prod[ProdW-1 -: SB];
      end
    end
  end

  // Control-relevant state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      held_r  <= '0;
      decay_r <= rlm_pkg::DecayReset;
    end else begin
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
      decay_r <= decay_nxt;
    end
  end

  // Working registers of the divider and root unit.
  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    rad_r  <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

  assign out_level = rlm_pkg::LevelW'(held_r);

`ifndef SYNTHESIS
  // The sample count never passes the buffer limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAX_SAMPLES))
    else $error("sample count past the buffer limit");

  // The divider remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  // The held level never exceeds full scale.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, held_r} <= ((SB + 1)'(1) << (SB - 1)))
    else $error("held level above full scale");
`endif

endmodule

>>> hw/rtl/rms_level_meter_decay.sv
// Top level of the RMS level meter with peak hold and decay.
// Samples within a buffer are taken one word per cycle. The word that carries
// last_of_buffer starts the level computation: a restoring divider takes one
// quotient bit per cycle over the width of the square sum, then a root unit
// takes one bit per cycle, and then the held level is updated. The input
// stalls through the loads, the divider and root steps and the level update,
// and longer if the previous result word is still stalled. The result register
// lets the next buffer begin while a level waits to be taken.
// decay_factor must be written through the cfg port only while the block is
// idle; the block itself does not enforce this.
module rms_level_meter_decay #(
  parameter int unsigned MAX_SAMPLES = 8192,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_BITS-1:0]     in_sample,
  input  logic                       in_last_of_buffer,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rlm_pkg::LevelW-1:0] out_level,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rlm_pkg::CfgW-1:0]   cfg_data
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = 2 * SAMPLE_BITS - 1 + CntW;

  rlm_pkg::cmd_t cmd;

  // The decay register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  rlm_ctrl #(
    .DIV_STEPS  (SumW),
    .SQRT_STEPS (SAMPLE_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_last_of_buffer (in_last_of_buffer),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .cmd               (cmd)
  );

  rlm_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_sample (in_sample),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_level (out_level)
  );

endmodule
